// File: sv/uvt_pkg.sv
package uvt_pkg;

   localparam int TableDepth = 32;
   localparam int ValueW     = 32;
   localparam int CountW     = 6;
   localparam int StatusW    = 3;

   typedef enum logic [StatusW-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_DUMPED    = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   // Request kinds carried in the request tuser bit.
   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_DUMP   = 1'b1
   } req_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       scan;
      logic       dump_read;
      logic       emit;
      logic       append;
      logic       last;
      status_type emit_status;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic hit;
      logic scan_done;
      logic full;
      logic empty;
      logic dump_last;
      logic out_free;
   } sts_type;

endpackage

// File: sv/unique_value_table_core.sv
// Channel    Direction  Transaction contents
// req_*      in         tuser: req_type (0 insert, 1 dump); tdata: value
// rsp_*      out        tuser: status; tdata: entry_value, entry_count; tlast: last
//
// An insert with no match steps through accept, one read per stored entry, the final
// compare, the scan end, and the result load. A dump reads and then emits each entry
// in turn through the single read port; an empty table gives one ST_EMPTY result.
// Reset is synchronous and active high; it empties the table at once.
// A stalled result channel holds the controller in its reply or dump-emit state; one finished
// result can wait in the output register while the next request is accepted.
module unique_value_table_core #(
   parameter int TABLE_DEPTH = uvt_pkg::TableDepth
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [0:0]  req_tuser,   // [0] req_type
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] entry_value, [37:32] entry_count, [39:38] zero
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast
);

   uvt_pkg::cmd_type cmd;
   uvt_pkg::sts_type sts;

   logic [uvt_pkg::ValueW-1:0]  rsp_value;
   logic [uvt_pkg::CountW-1:0]  rsp_count;
   logic [uvt_pkg::StatusW-1:0] rsp_status;

   // The controller sequences the scan, the reply and the dump walk.
   uvt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_dump   (req_tuser[0]),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the table memory, the fill count, the scan index and
   // the result register.
   uvt_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_count, rsp_value};
   assign rsp_tuser = rsp_status;

   // A result is only loaded when the output register is free to take it.
   a_emit_free : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result loaded over a pending transaction");

   // An append never happens on a full table.
   a_append_room : assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> !sts.full)
      else $error("append into a full table");

   // An empty-table result is the only result of its request and carries zeros.
   a_empty_shape : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == uvt_pkg::ST_EMPTY) |-> (rsp_tlast && rsp_tdata == 40'd0))
      else $error("malformed empty-table result");

   // A new request is never taken in the middle of a scan or dump.
   a_capture_idle : assert property (@(posedge clock) disable iff (reset)
      (cmd.scan || cmd.dump_read) |-> !req_tready)
      else $error("request accepted while busy");

endmodule

// File: sv/uvt_ram.sv
module uvt_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/uvt_ctrl.sv
module uvt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_dump,
   output logic              req_tready,
   input  uvt_pkg::sts_type  sts,
   output uvt_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_REPLY,
      S_DREAD,
      S_DEMIT
   } state_type;

   state_type           state_ff, state_in;
   uvt_pkg::status_type kind_ff, kind_in;

   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      cmd             = '0;
      cmd.emit_status = uvt_pkg::ST_INSERTED;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               if (!req_dump) begin
                  state_in = S_SCAN;
               end else if (sts.empty) begin
                  kind_in  = uvt_pkg::ST_EMPTY;
                  state_in = S_REPLY;
               end else begin
                  state_in = S_DREAD;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            // A match wins over a full table.
            if (sts.hit) begin
               kind_in  = uvt_pkg::ST_DUPLICATE;
               state_in = S_REPLY;
            end else if (sts.scan_done) begin
               kind_in  = sts.full ? uvt_pkg::ST_FULL : uvt_pkg::ST_INSERTED;
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.last        = 1'b1;
               cmd.emit_status = kind_ff;
               cmd.append      = (kind_ff == uvt_pkg::ST_INSERTED);
               state_in        = S_IDLE;
            end
         end
         S_DREAD: begin
            cmd.dump_read = 1'b1;
            state_in      = S_DEMIT;
         end
         S_DEMIT: begin
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.last        = sts.dump_last;
               cmd.emit_status = uvt_pkg::ST_DUMPED;
               state_in        = sts.dump_last ? S_IDLE : S_DREAD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= uvt_pkg::ST_INSERTED;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

// File: sv/uvt_dpath.sv
module uvt_dpath #(
   parameter int TABLE_DEPTH = uvt_pkg::TableDepth
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [uvt_pkg::ValueW-1:0]  req_value,
   input  uvt_pkg::cmd_type            cmd,
   output uvt_pkg::sts_type            sts,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [uvt_pkg::ValueW-1:0]  rsp_value,
   output logic [uvt_pkg::CountW-1:0]  rsp_count,
   output logic [uvt_pkg::StatusW-1:0] rsp_status,
   output logic                        rsp_last
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = $clog2(TABLE_DEPTH);

   logic [uvt_pkg::ValueW-1:0]  val_ff, val_in;
   logic [CW-1:0]               idx_ff, idx_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic                        rv_ff, rv_in;
   logic                        out_valid_ff, out_valid_in;
   logic [uvt_pkg::ValueW-1:0]  out_value_ff, out_value_in;
   logic [uvt_pkg::CountW-1:0]  out_count_ff, out_count_in;
   logic [uvt_pkg::StatusW-1:0] out_status_ff, out_status_in;
   logic                        out_last_ff, out_last_in;

   logic                        idx_lt;
   logic                        rd_en;
   logic [uvt_pkg::ValueW-1:0]  rd_data;
   logic [CW+uvt_pkg::CountW-1:0] count_ext;

   assign idx_lt = (idx_ff < cnt_ff);
   assign rd_en  = (cmd.scan && idx_lt) || cmd.dump_read;

   uvt_ram #(
      .Width (uvt_pkg::ValueW),
      .Depth (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (cnt_ff[IW-1:0]),
      .wr_data (val_ff),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      val_in = cmd.capture ? req_value : val_ff;

      if (cmd.capture) begin
         idx_in = '0;
      end else if (rd_en) begin
         idx_in = idx_ff + CW'(1);
      end else begin
         idx_in = idx_ff;
      end

      rv_in  = cmd.scan && idx_lt;
      cnt_in = cmd.append ? (cnt_ff + CW'(1)) : cnt_ff;

      // The count field keeps the low bits of the count after this request.
      count_ext = {{uvt_pkg::CountW{1'b0}}, cnt_in};

      out_value_in  = out_value_ff;
      out_count_in  = out_count_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      if (cmd.emit) begin
         out_valid_in  = 1'b1;
         out_count_in  = count_ext[uvt_pkg::CountW-1:0];
         out_status_in = cmd.emit_status;
         out_last_in   = cmd.last;
         if (cmd.emit_status == uvt_pkg::ST_DUMPED) begin
            out_value_in = rd_data;
         end else if (cmd.emit_status == uvt_pkg::ST_EMPTY) begin
            out_value_in = '0;
         end else begin
            out_value_in = val_ff;
         end
      end else begin
         out_valid_in = out_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rv_ff        <= rv_in;
         out_valid_ff <= out_valid_in;
      end
      val_ff        <= val_in;
      out_value_ff  <= out_value_in;
      out_count_ff  <= out_count_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign sts.hit       = rv_ff && (rd_data == val_ff);
   assign sts.scan_done = !idx_lt && !rv_ff;
   assign sts.full      = (cnt_ff == CW'(TABLE_DEPTH));
   assign sts.empty     = (cnt_ff == '0);
   assign sts.dump_last = (idx_ff == cnt_ff);
   assign sts.out_free  = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_count  = out_count_ff;
   assign rsp_status = out_status_ff;
   assign rsp_last   = out_last_ff;

endmodule
